FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must never hold outside reset.
`define ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

FILE: rtl/rsem_pkg.sv
// Types and constants for the RGB Sobel edge magnitude block.
`default_nettype none
package rsem_pkg;

  localparam int unsigned PIX_W   = 24;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned REG_W   = 12;
  localparam int unsigned GRAD_W  = 11;
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned WIN_N   = 9;

  localparam logic [REG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [REG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [CHAN_W-1:0] MAG_SAT   = 8'd255;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_GRAD,
    ST_SQ,
    ST_ROOT,
    ST_OUT
  } state_e;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PIX_W-1:0]  pix_t;

endpackage
`default_nettype wire

FILE: rtl/rgb_sobel_edge_magnitude.sv
// Top level: streaming 3x3 Sobel edge magnitude over RGB pixels.
// Each beat passes through accept and line buffer write-back; a beat with a result also
// passes through gradient, squares, an 8-step square root loop and the output load.
// One beat at a time; a result waits in the output register while m_axis_tready is low.
// Results lag the input by width+1 beats. rst_ni clears counters, window and
// registers (width 640, height 480); the line buffer RAM is not cleared.
`default_nettype none
`include "assert_macros.svh"
module rgb_sobel_edge_magnitude import rsem_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_addr_i,
  input  wire logic [REG_W-1:0]  cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [PIX_W-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
  input  wire logic              s_axis_tuser,   // is_flush
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [PIX_W-1:0]  m_axis_tdata,   // red_out, green_out, blue_out
  output logic                   m_axis_tlast    // frame_last
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HR = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = HR + 2;

  state_e state_q, state_d;

  logic [REG_W-1:0] width_q, height_q;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;

  logic [CW-1:0] in_col_q;
  logic [RW-1:0] in_row_q;
  logic [CW-1:0] ocol_q;
  logic [HR-1:0] orow_q;

  pix_t            pix_q;
  logic [CW-1:0]   col_q;
  logic            emit_q, last_q;
  logic [WIN_N-1:0] ok_q;
  pix_t            win_q [WIN_N];

  logic signed [GRAD_W-1:0] gx_q [3];
  logic signed [GRAD_W-1:0] gy_q [3];
  logic signed [GRAD_W-1:0] gx_d [3];
  logic signed [GRAD_W-1:0] gy_d [3];
  logic [SUM_W-1:0] sum_q [3];
  chan_t            root_q [3];
  logic [2:0]       cnt_q;

  logic             out_vld_q, out_last_q;
  pix_t             out_data_q;

  logic             accept, ram_we, out_load, out_room;
  logic [2*PIX_W-1:0] ram_rdata;

  // effective frame size, clamped to 1..MAX
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_RD;
      ST_RD:   state_d = emit_q ? ST_GRAD : ST_IDLE;
      ST_GRAD: state_d = ST_SQ;
      ST_SQ:   state_d = ST_ROOT;
      ST_ROOT: if (cnt_q == 3'd7) state_d = ST_OUT;
      ST_OUT:  if (out_room) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    out_room      = !out_vld_q || m_axis_tready;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_RD:   ram_we        = 1'b1;
      ST_OUT:  out_load      = out_room;
      default: ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // upper row in the high half, middle row in the low half
  rsem_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i ({ram_rdata[PIX_W-1:0], pix_q}),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  // gradients of the current window
  always_comb begin
    logic signed [GRAD_W-1:0] p [WIN_N];
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < WIN_N; k++) begin
        p[k] = ok_q[k] ? $signed({3'b000, win_q[k][PIX_W-1-CHAN_W*ch -: CHAN_W]})
                       : '0;
      end
      gx_d[ch] = (p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]);
      gy_d[ch] = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
      in_col_q  <= '0;
      in_row_q  <= '0;
      ocol_q    <= '0;
      orow_q    <= '0;
      emit_q    <= 1'b0;
      last_q    <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < WIN_N; k++) win_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_WIDTH) width_q <= cfg_wdata_i;
        else                         height_q <= cfg_wdata_i;
        in_col_q <= '0;
        in_row_q <= '0;
        ocol_q   <= '0;
        orow_q   <= '0;
        for (int k = 0; k < WIN_N; k++) win_q[k] <= '0;
      end else if (accept) begin
        logic emit, last;
        emit   = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
        last   = (WW'(ocol_q) == w_eff - WW'(1)) && (HW'(orow_q) == h_eff - HW'(1));
        emit_q <= emit;
        last_q <= emit && last;
        if (emit && last) begin
          in_col_q <= '0;
          in_row_q <= '0;
          ocol_q   <= '0;
          orow_q   <= '0;
        end else begin
          if (WW'(in_col_q) + WW'(1) >= w_eff) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + RW'(1);
          end else begin
            in_col_q <= in_col_q + CW'(1);
          end
          if (emit) begin
            if (WW'(ocol_q) == w_eff - WW'(1)) begin
              ocol_q <= '0;
              orow_q <= orow_q + HR'(1);
            end else begin
              ocol_q <= ocol_q + CW'(1);
            end
          end
        end
      end
      if (state_q == ST_RD) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= ram_rdata[2*PIX_W-1:PIX_W];
        win_q[5] <= ram_rdata[PIX_W-1:0];
        win_q[8] <= pix_q;
      end
      // frame end: window cleared once its last gradient is taken
      if (state_q == ST_GRAD && last_q) begin
        for (int k = 0; k < WIN_N; k++) win_q[k] <= '0;
      end
      if (state_q == ST_SQ) cnt_q <= '0;
      else if (state_q == ST_ROOT) cnt_q <= cnt_q + 3'd1;
      if (out_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      logic up, dn, lf, rt;
      up = orow_q != '0;
      dn = HW'(orow_q) != h_eff - HW'(1);
      lf = ocol_q != '0;
      rt = WW'(ocol_q) != w_eff - WW'(1);
      pix_q <= (!s_axis_tuser && in_row_q < RW'(h_eff)) ? s_axis_tdata : '0;
      col_q <= in_col_q;
      ok_q  <= {dn && rt, dn, dn && lf, rt, 1'b1, lf, up && rt, up, up && lf};
    end
    if (state_q == ST_GRAD) begin
      for (int ch = 0; ch < 3; ch++) begin
        gx_q[ch] <= gx_d[ch];
        gy_q[ch] <= gy_d[ch];
      end
    end
    if (state_q == ST_SQ) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic signed [2*GRAD_W-1:0] sx, sy;
        logic [2*GRAD_W-1:0] s;
        sx = gx_q[ch] * gx_q[ch];
        sy = gy_q[ch] * gy_q[ch];
        s  = sx + sy;
        sum_q[ch]  <= s[SUM_W-1:0];
        root_q[ch] <= '0;
      end
    end
    // one result bit per cycle, MSB first
    if (state_q == ST_ROOT) begin
      for (int ch = 0; ch < 3; ch++) begin
        chan_t t;
        logic [2*CHAN_W-1:0] tt;
        t  = root_q[ch] | (chan_t'(8'h80) >> cnt_q);
        tt = t * t;
        if (SUM_W'(tt) <= sum_q[ch]) root_q[ch] <= t;
      end
    end
    if (out_load) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_data_q[PIX_W-1-CHAN_W*ch -: CHAN_W] <=
          (sum_q[ch][SUM_W-1:2*CHAN_W] != '0) ? MAG_SAT : root_q[ch];
      end
      out_last_q <= last_q;
    end
  end

  // channel order on the bus: red in the high byte
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `ASSERT_CLK(a_rd_next, state_q == ST_RD |=> state_q == ST_IDLE || state_q == ST_GRAD,
              "line buffer read not followed by idle or gradient")
  `ASSERT_CLK(a_ocol_range, WW'(ocol_q) < w_eff && HW'(orow_q) < h_eff,
              "output position outside frame")
  `ASSERT_NEVER(a_load_busy, out_load && out_vld_q && !m_axis_tready,
                "result overwrote a pending beat")

endmodule
`default_nettype wire

FILE: rtl/rsem_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rsem_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: tb/rsem_checker.sv
// Checker for the RGB Sobel block: tracks config and input beats, predicts results, compares.
`timescale 1ns / 100ps
module rsem_checker import rsem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [REG_W-1:0] cfg_wdata_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [PIX_W-1:0] s_tdata_i,  // red, green, blue from the top byte down
  input  logic             s_tuser_i,  // is_flush
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [PIX_W-1:0] m_tdata_i,  // red, green, blue magnitudes
  input  logic             m_tlast_i,  // frame_last
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] mag;
    logic             last;
  } edge_res_t;

  edge_res_t        mag_q[$];
  logic [PIX_W-1:0] upper_line[2048];
  logic [PIX_W-1:0] middle_line[2048];
  logic [PIX_W-1:0] win[9];
  logic [REG_W-1:0] width_reg, height_reg;
  int unsigned      col_cnt, row_cnt, pix_cnt;
  int               err_cnt = 0;

  assign pending_o = mag_q.size();
  assign errors_o  = err_cnt;

  function automatic logic [7:0] sat_root(int unsigned sum);
    logic [7:0] r;
    r = '0;
    if (sum >= 65536) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      logic [7:0] t;
      t = r | (8'd1 << b);
      if (int'(t) * int'(t) <= sum) r = t;
    end
    return r;
  endfunction

  function automatic int unsigned clamp_dim(logic [REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 2048) return 2048;
    return v;
  endfunction

  task automatic restart_frame();
    col_cnt = 0;
    row_cnt = 0;
    pix_cnt = 0;
    for (int k = 0; k < 9; k++) win[k] = '0;
  endtask

  task automatic predict_beat(logic [PIX_W-1:0] data, logic flush);
    int unsigned w, h, orow, ocol, c;
    logic [PIX_W-1:0] v, top, mid, mag;
    logic ok[9];
    logic up, dn, lf, rt, fires;
    int p[9];
    int gx, gy;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    v = (!flush && row_cnt < h) ? data : '0;
    c = col_cnt < 2048 ? col_cnt : 0;
    top = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = v;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = v;
    fires = row_cnt >= 2 || (row_cnt == 1 && col_cnt >= 1);
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (!fires) return;
    orow = pix_cnt / w;
    ocol = pix_cnt % w;
    up = orow >= 1; dn = orow + 1 < h; lf = ocol >= 1; rt = ocol + 1 < w;
    ok[0] = up && lf; ok[1] = up; ok[2] = up && rt;
    ok[3] = lf;       ok[4] = 1;  ok[5] = rt;
    ok[6] = dn && lf; ok[7] = dn; ok[8] = dn && rt;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) p[k] = ok[k] ? int'(win[k][16-8*ch +: 8]) : 0;
      gx = (p[2] + 2*p[5] + p[8]) - (p[0] + 2*p[3] + p[6]);
      gy = (p[6] + 2*p[7] + p[8]) - (p[0] + 2*p[1] + p[2]);
      mag[16-8*ch +: 8] = sat_root(gx*gx + gy*gy);
    end
    if (pix_cnt >= w*h - 1) begin
      mag_q.push_back('{mag: mag, last: 1'b1});
      restart_frame();
    end else begin
      mag_q.push_back('{mag: mag, last: 1'b0});
      pix_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      restart_frame();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (mag_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat %h last %b", $time, m_tdata_i, m_tlast_i);
        end else begin
          edge_res_t e;
          e = mag_q.pop_front();
          if (e.mag !== m_tdata_i || e.last !== m_tlast_i) begin
            err_cnt++;
            $display("%0t: mismatch expected %h last %b, actual %h last %b",
                     $time, e.mag, e.last, m_tdata_i, m_tlast_i);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_WIDTH) width_reg = cfg_wdata_i;
        else height_reg = cfg_wdata_i;
        restart_frame();
      end
      if (s_tvalid_i && s_tready_i) predict_beat(s_tdata_i, s_tuser_i);
    end
  end

  initial begin
    for (int k = 0; k < 2048; k++) begin
      upper_line[k] = '0;
      middle_line[k] = '0;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top: clock, reset, pixel stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module tb_top;
  import rsem_pkg::*;

  typedef logic bool_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_addr_i = REG_WIDTH;
  logic [REG_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [PIX_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  int               errors, pending;
  int               cycles = 0;
  int               sent = 0;
  int               burst_left = 0;
  bool_t            calm;
  logic             hold_go = 1'b0;

  always #2 clk_i = ~clk_i;

  rgb_sobel_edge_magnitude u_top (.*);

  rsem_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tlast_i(m_axis_tlast),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output side: ready pattern switches between random modes, one long hold-off
  initial begin
    int unsigned mode;
    bit held;
    held = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !held) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (500) @(negedge clk_i);
      end
      if (cycles % 256 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_item(logic [PIX_W-1:0] data, logic flush);
    if (!calm && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= flush;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_idle();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [REG_W-1:0] val);
    drain_idle();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int unsigned eff_dim(logic [REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 2048) return 2048;
    return v;
  endfunction

  // one frame of random pixels then the flush tail; cut drops part of the tail
  task automatic send_frame(int unsigned w, int unsigned h, bit cut);
    int unsigned tail;
    for (int unsigned i = 0; i < w*h; i++)
      send_item(PIX_W'($urandom_range(0, 24'hFFFFFF)), $urandom_range(0, 15) == 0);
    tail = cut ? $urandom_range(0, w) : w + 1;
    for (int unsigned i = 0; i < tail; i++)
      send_item(PIX_W'($urandom_range(0, 24'hFFFFFF)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [REG_W-1:0] wv, hv;
    calm = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: 3x3 frame with extremes, a black flush slot, pixels past frame end
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd3);
    send_item(24'hFFFFFF, 1'b0); send_item(24'h000000, 1'b0); send_item(24'hFFFFFF, 1'b0);
    send_item(24'h000000, 1'b0); send_item(24'hFF00FF, 1'b1); send_item(24'h00FF00, 1'b0);
    send_item(24'hFFFFFF, 1'b0); send_item(24'h0000FF, 1'b0); send_item(24'hFFFFFF, 1'b0);
    send_item(24'hFFFFFF, 1'b0); send_item(24'h000000, 1'b1);
    send_item(24'hFFFFFF, 1'b1); send_item(24'hFFFFFF, 1'b0);

    // out-of-range sizes saturate: 2049 acts as 2048, 0 acts as 1; long runs cut short
    write_reg(REG_WIDTH, 12'd2049);
    write_reg(REG_HEIGHT, 12'd2);
    for (int i = 0; i < 300; i++) send_item(PIX_W'($urandom_range(0, 24'hFFFFFF)), 1'b0);
    write_reg(REG_WIDTH, 12'd0);
    write_reg(REG_HEIGHT, 12'd2049);
    for (int i = 0; i < 300; i++) send_item(PIX_W'($urandom_range(0, 24'hFFFFFF)), 1'b0);
    write_reg(REG_HEIGHT, 12'd3);
    send_frame(1, 3, 0);
    write_reg(REG_WIDTH, 12'd5);
    write_reg(REG_HEIGHT, 12'd0);
    send_frame(5, 1, 0);
    write_reg(REG_HEIGHT, 12'd2);
    write_reg(REG_WIDTH, 12'd1);
    send_frame(1, 2, 0);

    while (sent < 1750) begin
      bit cut;
      calm = ($urandom_range(0, 3) == 0);
      wv = REG_W'($urandom_range(1, 9));
      hv = REG_W'($urandom_range(1, 6));
      write_reg(REG_WIDTH, wv);
      write_reg(REG_HEIGHT, hv);
      repeat ($urandom_range(1, 3)) begin
        cut = ($urandom_range(0, 7) == 0);
        if (sent > 600) hold_go = 1'b1;
        send_frame(eff_dim(wv), eff_dim(hv), cut);
        if (cut) break;
      end
      if ($urandom_range(0, 3) == 0) drain_idle();
    end

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
